/* rtl/sdm_pkg.sv */
package sdm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int DZ_MAX    = (ONE * 999) / 1000;
    localparam int CFG_W     = 15;

    localparam logic [0:0] REG_DEAD_ZONE = 1'b0;
    localparam logic [0:0] REG_RUN_THR   = 1'b1;

    localparam logic [13:0] DZ_RESET  = 14'd3277;
    localparam logic [14:0] THR_RESET = 15'd8192;

    typedef struct packed {
        logic               pres;
        logic               run;
        logic               jump;
        logic        [15:0] xm;
        logic        [15:0] ym;
        logic               xn;
        logic               yn;
        logic signed [15:0] kx;
        logic signed [15:0] ky;
        logic        [13:0] dz;
        logic        [31:0] xsq;
        logic        [31:0] ysq;
        logic        [27:0] dzsq;
        logic               live;
        logic        [31:0] sq;
        logic        [15:0] len;
        logic        [28:0] dn;
        logic        [29:0] pnx;
        logic        [29:0] pny;
        logic        [15:0] pdl;
        logic        [15:0] sxm;
        logic        [15:0] sym;
        logic               sxn;
        logic               syn;
        logic        [31:0] sxsq;
        logic        [31:0] sysq;
        logic        [32:0] lsq;
        logic               norm;
        logic        [29:0] n2x;
        logic        [29:0] n2y;
        logic        [16:0] d2;
        logic        [15:0] mx;
        logic        [15:0] my;
    } t_side;

    typedef struct packed {
        logic [15:0] mx;
        logic [15:0] my;
        logic        run;
        logic        jump;
    } t_out;

endpackage

/* rtl/sdm_sqrt_cell.sv */
module sdm_sqrt_cell #(
    parameter int VW = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [VW-1:0]   i_v,
    input  logic [VW/2+1:0] i_rem,
    input  logic [VW/2-1:0] i_root,
    output logic [VW-1:0]   o_v,
    output logic [VW/2+1:0] o_rem,
    output logic [VW/2-1:0] o_root
);
    localparam int RW = VW / 2;

    logic [RW+3:0] w_t;
    logic [RW+3:0] w_trial;
    logic [RW+3:0] w_diff;
    logic          w_ge;
    logic [VW-1:0] r_v;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;

    assign w_t     = {i_rem, i_v[VW-1:VW-2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_t - w_trial;
    assign w_ge    = (w_t >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= {i_v[VW-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[RW+1:0] : w_t[RW+1:0];
            r_root <= {i_root[RW-2:0], w_ge};
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

/* rtl/sdm_div_cell.sv */
module sdm_div_cell #(
    parameter int DW = 16,
    parameter int QW = 15
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [QW-1:0] i_n,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_d,
    input  logic [QW-1:0] i_q,
    output logic [QW-1:0] o_n,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_d,
    output logic [QW-1:0] o_q
);
    logic [DW:0]   w_t;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [QW-1:0] r_n;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [QW-1:0] r_q;

    assign w_t    = {i_rem, i_n[QW-1]};
    assign w_diff = w_t - {1'b0, i_d};
    assign w_ge   = (w_t >= {1'b0, i_d});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= {i_n[QW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
            r_d   <= i_d;
            r_q   <= {i_q[QW-2:0], w_ge};
        end
    end

    assign o_n   = r_n;
    assign o_rem = r_rem;
    assign o_d   = r_d;
    assign o_q   = r_q;

endmodule

/* rtl/stick_dead_zone_and_move_merge.sv */
// Throughput: one beat per cycle while the skid stage is empty; a chain
// of 87 stages (two 1-bit-per-cell square roots, five 1-bit-per-cell
// dividers) advances as a whole. A two-entry output register and skid
// stage decouple the output stall. Reset (synchronous, active low)
// empties the chain and output stages and sets dead_zone to 3277 and
// run_threshold to 8192.
module stick_dead_zone_and_move_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_pad_present,
    input  logic signed [15:0] i_stick_x,
    input  logic signed [15:0] i_stick_y,
    input  logic [14:0]        i_trigger_level,
    input  logic               i_pad_jump,
    input  logic signed [15:0] i_key_move_x,
    input  logic signed [15:0] i_key_move_y,
    input  logic               i_key_run,
    input  logic               i_key_jump,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_move_x,
    output logic signed [15:0] o_move_y,
    output logic               o_run_flag,
    output logic               o_jump_flag
);
    localparam int SQ1_N    = 16;
    localparam int SQ2_N    = 17;
    localparam int DIV_N    = 15;
    localparam int ST_SQ1   = 2;
    localparam int ST_PREPR = ST_SQ1 + SQ1_N;
    localparam int ST_DIVR  = ST_PREPR + 1;
    localparam int ST_MUL   = ST_DIVR + DIV_N;
    localparam int ST_DIVP  = ST_MUL + 1;
    localparam int ST_SUM   = ST_DIVP + DIV_N;
    localparam int ST_SQS   = ST_SUM + 1;
    localparam int ST_LSQ   = ST_SQS + 1;
    localparam int ST_SQ2   = ST_LSQ + 1;
    localparam int ST_PREP2 = ST_SQ2 + SQ2_N;
    localparam int ST_DIV2  = ST_PREP2 + 1;
    localparam int ST_FIN   = ST_DIV2 + DIV_N;
    localparam int L        = ST_FIN + 1;
    localparam logic [32:0] ONE_SQ = 33'(sdm_pkg::ONE) * 33'(sdm_pkg::ONE);

    logic [13:0]       r_dz;
    logic [14:0]       r_thr;
    logic              w_en;
    logic [L-1:0]      r_vld;
    sdm_pkg::t_side    r_sd [0:L-1];
    sdm_pkg::t_side    n_sd [0:L-1];
    logic              r_skid_vld;
    sdm_pkg::t_out     r_skid;
    sdm_pkg::t_out     r_out;
    sdm_pkg::t_out     w_tail;

    logic [15:0]       w_xm;
    logic [15:0]       w_ym;
    logic [13:0]       w_dzc;
    logic [14:0]       w_thrc;
    logic [14:0]       w_c;
    logic signed [17:0] w_pxs;
    logic signed [17:0] w_pys;
    logic signed [17:0] w_sx;
    logic signed [17:0] w_sy;

    logic [31:0] w_s1_v    [0:SQ1_N];
    logic [17:0] w_s1_rem  [0:SQ1_N];
    logic [15:0] w_s1_root [0:SQ1_N];
    logic [33:0] w_s2_v    [0:SQ2_N];
    logic [18:0] w_s2_rem  [0:SQ2_N];
    logic [16:0] w_s2_root [0:SQ2_N];
    logic [14:0] w_dr_n    [0:DIV_N];
    logic [14:0] w_dr_rem  [0:DIV_N];
    logic [14:0] w_dr_d    [0:DIV_N];
    logic [14:0] w_dr_q    [0:DIV_N];
    logic [14:0] w_dx_n    [0:DIV_N];
    logic [15:0] w_dx_rem  [0:DIV_N];
    logic [15:0] w_dx_d    [0:DIV_N];
    logic [14:0] w_dx_q    [0:DIV_N];
    logic [14:0] w_dy_n    [0:DIV_N];
    logic [15:0] w_dy_rem  [0:DIV_N];
    logic [15:0] w_dy_d    [0:DIV_N];
    logic [14:0] w_dy_q    [0:DIV_N];
    logic [14:0] w_ex_n    [0:DIV_N];
    logic [16:0] w_ex_rem  [0:DIV_N];
    logic [16:0] w_ex_d    [0:DIV_N];
    logic [14:0] w_ex_q    [0:DIV_N];
    logic [14:0] w_ey_n    [0:DIV_N];
    logic [16:0] w_ey_rem  [0:DIV_N];
    logic [16:0] w_ey_d    [0:DIV_N];
    logic [14:0] w_ey_q    [0:DIV_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz  <= sdm_pkg::DZ_RESET;
            r_thr <= sdm_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdm_pkg::REG_DEAD_ZONE: r_dz  <= i_cfg_data[13:0];
                sdm_pkg::REG_RUN_THR:   r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;

    assign w_xm   = i_stick_x[15] ? 16'(~i_stick_x + 16'sd1) : 16'(i_stick_x);
    assign w_ym   = i_stick_y[15] ? 16'(~i_stick_y + 16'sd1) : 16'(i_stick_y);
    assign w_dzc  = (r_dz > 14'(sdm_pkg::DZ_MAX)) ? 14'(sdm_pkg::DZ_MAX) : r_dz;
    assign w_thrc = (r_thr > 15'(sdm_pkg::ONE)) ? 15'(sdm_pkg::ONE) : r_thr;
    assign w_c    = (w_s1_root[SQ1_N] > 16'(sdm_pkg::ONE)) ? 15'(sdm_pkg::ONE)
                                                           : w_s1_root[SQ1_N][14:0];

    assign w_pxs = r_sd[ST_SUM-1].xn ? -$signed({3'b000, w_dx_q[DIV_N]})
                                     : $signed({3'b000, w_dx_q[DIV_N]});
    assign w_pys = r_sd[ST_SUM-1].yn ? -$signed({3'b000, w_dy_q[DIV_N]})
                                     : $signed({3'b000, w_dy_q[DIV_N]});
    assign w_sx  = $signed({{2{r_sd[ST_SUM-1].kx[15]}}, r_sd[ST_SUM-1].kx}) + w_pxs;
    assign w_sy  = $signed({{2{r_sd[ST_SUM-1].ky[15]}}, r_sd[ST_SUM-1].ky}) + w_pys;

    always_comb begin
        n_sd[0]      = '0;
        n_sd[0].pres = i_pad_present;
        n_sd[0].run  = i_key_run || (i_pad_present && (i_trigger_level >= w_thrc));
        n_sd[0].jump = i_key_jump || (i_pad_present && i_pad_jump);
        n_sd[0].xm   = w_xm;
        n_sd[0].ym   = w_ym;
        n_sd[0].xn   = i_stick_x[15];
        n_sd[0].yn   = i_stick_y[15];
        n_sd[0].kx   = i_key_move_x;
        n_sd[0].ky   = i_key_move_y;
        n_sd[0].dz   = w_dzc;
        n_sd[0].xsq  = 32'(w_xm) * 32'(w_xm);
        n_sd[0].ysq  = 32'(w_ym) * 32'(w_ym);
        n_sd[0].dzsq = 28'(w_dzc) * 28'(w_dzc);
        for (int k = 1; k < L; k++) begin
            n_sd[k] = r_sd[k-1];
        end

        n_sd[1].sq   = r_sd[0].xsq + r_sd[0].ysq;
        n_sd[1].live = r_sd[0].pres && ((r_sd[0].xsq + r_sd[0].ysq) > 32'(r_sd[0].dzsq));

        n_sd[ST_PREPR].len = w_s1_root[SQ1_N];
        n_sd[ST_PREPR].dn  = r_sd[ST_PREPR-1].live
                           ? {w_c - {1'b0, r_sd[ST_PREPR-1].dz}, 14'd0} : 29'd0;

        n_sd[ST_MUL].pnx = 30'(r_sd[ST_MUL-1].xm) * 30'(w_dr_q[DIV_N]);
        n_sd[ST_MUL].pny = 30'(r_sd[ST_MUL-1].ym) * 30'(w_dr_q[DIV_N]);
        n_sd[ST_MUL].pdl = r_sd[ST_MUL-1].live ? r_sd[ST_MUL-1].len : 16'd1;

        n_sd[ST_SUM].sxn = w_sx[17];
        n_sd[ST_SUM].syn = w_sy[17];
        n_sd[ST_SUM].sxm = w_sx[17] ? 16'(-w_sx) : w_sx[15:0];
        n_sd[ST_SUM].sym = w_sy[17] ? 16'(-w_sy) : w_sy[15:0];

        n_sd[ST_SQS].sxsq = 32'(r_sd[ST_SQS-1].sxm) * 32'(r_sd[ST_SQS-1].sxm);
        n_sd[ST_SQS].sysq = 32'(r_sd[ST_SQS-1].sym) * 32'(r_sd[ST_SQS-1].sym);

        n_sd[ST_LSQ].lsq  = 33'(r_sd[ST_LSQ-1].sxsq) + 33'(r_sd[ST_LSQ-1].sysq);
        n_sd[ST_LSQ].norm = (33'(r_sd[ST_LSQ-1].sxsq) + 33'(r_sd[ST_LSQ-1].sysq)) > ONE_SQ;

        n_sd[ST_PREP2].n2x = r_sd[ST_PREP2-1].norm ? {r_sd[ST_PREP2-1].sxm, 14'd0} : 30'd0;
        n_sd[ST_PREP2].n2y = r_sd[ST_PREP2-1].norm ? {r_sd[ST_PREP2-1].sym, 14'd0} : 30'd0;
        n_sd[ST_PREP2].d2  = r_sd[ST_PREP2-1].norm ? w_s2_root[SQ2_N] : 17'd1;

        if (r_sd[ST_FIN-1].norm) begin
            n_sd[ST_FIN].mx = r_sd[ST_FIN-1].sxn ? 16'(-{1'b0, w_ex_q[DIV_N]})
                                                 : {1'b0, w_ex_q[DIV_N]};
            n_sd[ST_FIN].my = r_sd[ST_FIN-1].syn ? 16'(-{1'b0, w_ey_q[DIV_N]})
                                                 : {1'b0, w_ey_q[DIV_N]};
        end else begin
            n_sd[ST_FIN].mx = r_sd[ST_FIN-1].sxn ? 16'(-r_sd[ST_FIN-1].sxm)
                                                 : r_sd[ST_FIN-1].sxm;
            n_sd[ST_FIN].my = r_sd[ST_FIN-1].syn ? 16'(-r_sd[ST_FIN-1].sym)
                                                 : r_sd[ST_FIN-1].sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd <= n_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // first square root: stick radius
    assign w_s1_v[0]    = r_sd[ST_SQ1-1].sq;
    assign w_s1_rem[0]  = '0;
    assign w_s1_root[0] = '0;
    for (genvar g = 0; g < SQ1_N; g++) begin : g_sq1
        sdm_sqrt_cell #(.VW(32)) u_cell (
            .i_clk(i_clk), .i_en(w_en),
            .i_v(w_s1_v[g]), .i_rem(w_s1_rem[g]), .i_root(w_s1_root[g]),
            .o_v(w_s1_v[g+1]), .o_rem(w_s1_rem[g+1]), .o_root(w_s1_root[g+1])
        );
    end

    // remap ratio
    assign w_dr_n[0]   = r_sd[ST_DIVR-1].dn[14:0];
    assign w_dr_rem[0] = {1'b0, r_sd[ST_DIVR-1].dn[28:15]};
    assign w_dr_d[0]   = 15'(sdm_pkg::ONE) - {1'b0, r_sd[ST_DIVR-1].dz};
    assign w_dr_q[0]   = '0;
    for (genvar g = 0; g < DIV_N; g++) begin : g_divr
        sdm_div_cell #(.DW(15), .QW(15)) u_cell (
            .i_clk(i_clk), .i_en(w_en),
            .i_n(w_dr_n[g]), .i_rem(w_dr_rem[g]), .i_d(w_dr_d[g]), .i_q(w_dr_q[g]),
            .o_n(w_dr_n[g+1]), .o_rem(w_dr_rem[g+1]), .o_d(w_dr_d[g+1]), .o_q(w_dr_q[g+1])
        );
    end

    // stick components over radius
    assign w_dx_n[0]   = r_sd[ST_DIVP-1].pnx[14:0];
    assign w_dx_rem[0] = {1'b0, r_sd[ST_DIVP-1].pnx[29:15]};
    assign w_dx_d[0]   = r_sd[ST_DIVP-1].pdl;
    assign w_dx_q[0]   = '0;
    assign w_dy_n[0]   = r_sd[ST_DIVP-1].pny[14:0];
    assign w_dy_rem[0] = {1'b0, r_sd[ST_DIVP-1].pny[29:15]};
    assign w_dy_d[0]   = r_sd[ST_DIVP-1].pdl;
    assign w_dy_q[0]   = '0;
    for (genvar g = 0; g < DIV_N; g++) begin : g_divp
        sdm_div_cell #(.DW(16), .QW(15)) u_cx (
            .i_clk(i_clk), .i_en(w_en),
            .i_n(w_dx_n[g]), .i_rem(w_dx_rem[g]), .i_d(w_dx_d[g]), .i_q(w_dx_q[g]),
            .o_n(w_dx_n[g+1]), .o_rem(w_dx_rem[g+1]), .o_d(w_dx_d[g+1]), .o_q(w_dx_q[g+1])
        );
        sdm_div_cell #(.DW(16), .QW(15)) u_cy (
            .i_clk(i_clk), .i_en(w_en),
            .i_n(w_dy_n[g]), .i_rem(w_dy_rem[g]), .i_d(w_dy_d[g]), .i_q(w_dy_q[g]),
            .o_n(w_dy_n[g+1]), .o_rem(w_dy_rem[g+1]), .o_d(w_dy_d[g+1]), .o_q(w_dy_q[g+1])
        );
    end

    // second square root: merged length
    assign w_s2_v[0]    = {1'b0, r_sd[ST_SQ2-1].lsq};
    assign w_s2_rem[0]  = '0;
    assign w_s2_root[0] = '0;
    for (genvar g = 0; g < SQ2_N; g++) begin : g_sq2
        sdm_sqrt_cell #(.VW(34)) u_cell (
            .i_clk(i_clk), .i_en(w_en),
            .i_v(w_s2_v[g]), .i_rem(w_s2_rem[g]), .i_root(w_s2_root[g]),
            .o_v(w_s2_v[g+1]), .o_rem(w_s2_rem[g+1]), .o_root(w_s2_root[g+1])
        );
    end

    // normalize merged vector
    assign w_ex_n[0]   = r_sd[ST_DIV2-1].n2x[14:0];
    assign w_ex_rem[0] = {2'b00, r_sd[ST_DIV2-1].n2x[29:15]};
    assign w_ex_d[0]   = r_sd[ST_DIV2-1].d2;
    assign w_ex_q[0]   = '0;
    assign w_ey_n[0]   = r_sd[ST_DIV2-1].n2y[14:0];
    assign w_ey_rem[0] = {2'b00, r_sd[ST_DIV2-1].n2y[29:15]};
    assign w_ey_d[0]   = r_sd[ST_DIV2-1].d2;
    assign w_ey_q[0]   = '0;
    for (genvar g = 0; g < DIV_N; g++) begin : g_div2
        sdm_div_cell #(.DW(17), .QW(15)) u_cx (
            .i_clk(i_clk), .i_en(w_en),
            .i_n(w_ex_n[g]), .i_rem(w_ex_rem[g]), .i_d(w_ex_d[g]), .i_q(w_ex_q[g]),
            .o_n(w_ex_n[g+1]), .o_rem(w_ex_rem[g+1]), .o_d(w_ex_d[g+1]), .o_q(w_ex_q[g+1])
        );
        sdm_div_cell #(.DW(17), .QW(15)) u_cy (
            .i_clk(i_clk), .i_en(w_en),
            .i_n(w_ey_n[g]), .i_rem(w_ey_rem[g]), .i_d(w_ey_d[g]), .i_q(w_ey_q[g]),
            .o_n(w_ey_n[g+1]), .o_rem(w_ey_rem[g+1]), .o_d(w_ey_d[g+1]), .o_q(w_ey_q[g+1])
        );
    end

    assign w_tail.mx   = r_sd[L-1].mx;
    assign w_tail.my   = r_sd[L-1].my;
    assign w_tail.run  = r_sd[L-1].run;
    assign w_tail.jump = r_sd[L-1].jump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid    <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_stall) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!o_valid || !i_stall) begin
            o_valid <= r_vld[L-1];
        end else if (r_vld[L-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (!o_valid || !i_stall) begin
            r_out <= w_tail;
        end else begin
            r_skid <= w_tail;
        end
    end

    assign o_move_x    = $signed(r_out.mx);
    assign o_move_y    = $signed(r_out.my);
    assign o_run_flag  = r_out.run;
    assign o_jump_flag = r_out.jump;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> o_valid)
        else $error("skid holds a beat with no output beat");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_stall) |=> !r_skid_vld)
        else $error("skid did not drain");

    a_unit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_move_x <= 16'sd16384) && (o_move_x >= -16'sd16384) &&
                     (o_move_y <= 16'sd16384) && (o_move_y >= -16'sd16384)))
        else $error("move component beyond one");

endmodule

/* bench/tb_stick_dead_zone_and_move_merge.sv */
`timescale 1ns / 1ps
module tb_stick_dead_zone_and_move_merge;

    localparam int LATENCY   = 87;
    localparam int WD_LIMIT  = 4000;
    localparam int N_RANDOM  = 1030;

    typedef struct {
        logic        pres;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [14:0] trig;
        logic        pjump;
        logic [15:0] kx;
        logic [15:0] ky;
        logic        krun;
        logic        kjump;
    } t_sample;

    typedef struct packed {
        logic [15:0] mx;
        logic [15:0] my;
        logic        run;
        logic        jump;
    } t_move;

    typedef struct {
        t_sample s;
        logic    known;
        t_move   m;
    } t_row;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [0:0]         cfg_idx;
    logic [14:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               pad_present;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [14:0]        trigger_level;
    logic               pad_jump;
    logic signed [15:0] key_move_x;
    logic signed [15:0] key_move_y;
    logic               key_run;
    logic               key_jump;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               run_flag;
    logic               jump_flag;

    logic [13:0] dz_reg;
    logic [14:0] thr_reg;
    t_move       expected_moves[$];
    int          n_errors;
    int          idle_cycles;
    logic        feeding_done;

    stick_dead_zone_and_move_merge u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_pad_present(pad_present), .i_stick_x(stick_x), .i_stick_y(stick_y),
        .i_trigger_level(trigger_level), .i_pad_jump(pad_jump),
        .i_key_move_x(key_move_x), .i_key_move_y(key_move_y),
        .i_key_run(key_run), .i_key_jump(key_jump),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_move_x(move_x), .o_move_y(move_y),
        .o_run_flag(run_flag), .o_jump_flag(jump_flag)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint scale_mag(longint v, longint unsigned mul,
                                         longint unsigned div);
        longint unsigned mag;
        longint unsigned q;
        if (div == 0) return 0;
        mag = (v < 0) ? -v : v;
        q = mag * mul / div;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_move merge_move(t_sample s);
        t_move m;
        longint x, y, px, py, sx, sy;
        longint unsigned dz, thr, sq, len, c, r, lsq;
        logic prun, pjmp;
        px = 0; py = 0; prun = 0; pjmp = 0;
        if (s.pres) begin
            x = longint'($signed(s.sx));
            y = longint'($signed(s.sy));
            dz = (dz_reg < sdm_pkg::DZ_MAX) ? dz_reg : sdm_pkg::DZ_MAX;
            thr = (thr_reg < sdm_pkg::ONE) ? thr_reg : sdm_pkg::ONE;
            sq = x * x + y * y;
            if (sq > dz * dz) begin
                len = int_sqrt(sq);
                if (len != 0) begin
                    c = (len < sdm_pkg::ONE) ? len : sdm_pkg::ONE;
                    r = ((c - dz) << sdm_pkg::FRAC_BITS) / (sdm_pkg::ONE - dz);
                    px = scale_mag(x, r, len);
                    py = scale_mag(y, r, len);
                end
            end
            prun = (s.trig >= thr);
            pjmp = s.pjump;
        end
        sx = longint'($signed(s.kx)) + px;
        sy = longint'($signed(s.ky)) + py;
        lsq = sx * sx + sy * sy;
        if (lsq > sdm_pkg::ONE * sdm_pkg::ONE) begin
            len = int_sqrt(lsq);
            sx = scale_mag(sx, sdm_pkg::ONE, len);
            sy = scale_mag(sy, sdm_pkg::ONE, len);
        end
        m.mx = sx[15:0];
        m.my = sy[15:0];
        m.run = s.krun | prun;
        m.jump = s.kjump | pjmp;
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [14:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == sdm_pkg::REG_DEAD_ZONE) dz_reg = val[13:0];
        else thr_reg = val;
    endtask

    task automatic drain;
        if (in_valid) in_valid <= 1'b0;
        while (expected_moves.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic send_sample(t_sample s, logic known, t_move m);
        int gap;
        t_move p;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        p = merge_move(s);
        if (known && p != m) report_mismatch("table row", p.mx, m.mx);
        in_valid <= 1'b1;
        pad_present <= s.pres;
        stick_x <= s.sx;
        stick_y <= s.sy;
        trigger_level <= s.trig;
        pad_jump <= s.pjump;
        key_move_x <= s.kx;
        key_move_y <= s.ky;
        key_run <= s.krun;
        key_jump <= s.kjump;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_moves.push_back(known ? m : p);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'(int'($urandom_range(0, 4000)) - 2000);
            2: return 16'(int'($urandom_range(0, 40000)) - 20000);
            3: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        s.pres = $urandom_range(0, 4) != 0;
        s.sx = rand_axis();
        s.sy = rand_axis();
        s.trig = ($urandom_range(0, 5) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
        s.pjump = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: begin s.kx = '0; s.ky = '0; end
            1: begin
                s.kx = 16'(16384 * (int'($urandom_range(0, 2)) - 1));
                s.ky = 16'(16384 * (int'($urandom_range(0, 2)) - 1));
            end
            2: begin s.kx = rand_axis(); s.ky = rand_axis(); end
            default: begin
                s.kx = 16'(int'($urandom_range(0, 32768)) - 16384);
                s.ky = 16'(int'($urandom_range(0, 32768)) - 16384);
            end
        endcase
        s.krun = 1'($urandom_range(0, 1));
        s.kjump = 1'($urandom_range(0, 1));
        return s;
    endfunction

    t_row directed[] = '{
        '{'{1'b1, 16'h0000, 16'h0000, 15'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0},
          1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0}},
        '{'{1'b1, 16'h4000, 16'h0000, 15'd8192, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0},
          1'b1, '{16'h4000, 16'h0000, 1'b1, 1'b1}},
        '{'{1'b1, 16'h0000, 16'hc000, 15'd8191, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0},
          1'b1, '{16'h0000, 16'hc000, 1'b0, 1'b0}},
        '{'{1'b0, 16'h7fff, 16'h7fff, 15'h7fff, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0},
          1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0}},
        '{'{1'b0, 16'h0000, 16'h0000, 15'd0, 1'b0, 16'h4000, 16'h0000, 1'b1, 1'b1},
          1'b1, '{16'h4000, 16'h0000, 1'b1, 1'b1}},
        '{'{1'b1, 16'h0cc0, 16'h0000, 15'h7fff, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0},
          1'b1, '{16'h0000, 16'h0000, 1'b1, 1'b0}},
        '{'{1'b1, 16'h8000, 16'h8000, 15'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0},
          1'b0, '{16'h0, 16'h0, 1'b0, 1'b0}},
        '{'{1'b1, 16'h7fff, 16'h8000, 15'd16384, 1'b1, 16'h7fff, 16'h8000, 1'b1, 1'b1},
          1'b0, '{16'h0, 16'h0, 1'b0, 1'b0}},
        '{'{1'b0, 16'h0000, 16'h0000, 15'd0, 1'b0, 16'h8000, 16'h7fff, 1'b0, 1'b0},
          1'b0, '{16'h0, 16'h0, 1'b0, 1'b0}},
        '{'{1'b1, 16'h2000, 16'h2000, 15'd100, 1'b0, 16'h4000, 16'h4000, 1'b0, 1'b1},
          1'b0, '{16'h0, 16'h0, 1'b0, 1'b0}},
        '{'{1'b1, 16'hf000, 16'h1000, 15'd9000, 1'b1, 16'hc000, 16'h0000, 1'b0, 1'b0},
          1'b0, '{16'h0, 16'h0, 1'b0, 1'b0}},
        '{'{1'b1, 16'h0ccd, 16'h0001, 15'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0},
          1'b0, '{16'h0, 16'h0, 1'b0, 1'b0}},
        '{'{1'b1, 16'h5555, 16'haaaa, 15'h2aaa, 1'b0, 16'h5555, 16'haaaa, 1'b1, 1'b0},
          1'b0, '{16'h0, 16'h0, 1'b0, 1'b0}}
    };

    always @(posedge clk) begin
        t_move want;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (out_valid && !out_stall) begin
                if (expected_moves.size() == 0) begin
                    report_mismatch("unexpected beat", move_x, 0);
                end else begin
                    want = expected_moves.pop_front();
                    if (move_x !== want.mx) report_mismatch("move_x", move_x, $signed(want.mx));
                    if (move_y !== want.my) report_mismatch("move_y", move_y, $signed(want.my));
                    if (run_flag !== want.run) report_mismatch("run_flag", run_flag, want.run);
                    if (jump_flag !== want.jump)
                        report_mismatch("jump_flag", jump_flag, want.jump);
                end
            end
        end
    end

    initial begin
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
            end else if (out_valid && !out_stall) begin
                hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                if (feeding_done && $urandom_range(0, 1)) hold = 0;
            end
            out_stall <= (hold > 0);
        end
    end

    initial begin
        t_move none;
        none = '{16'h0, 16'h0, 1'b0, 1'b0};
        n_errors = 0;
        idle_cycles = 0;
        feeding_done = 1'b0;
        dz_reg = sdm_pkg::DZ_RESET;
        thr_reg = sdm_pkg::THR_RESET;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= sdm_pkg::REG_DEAD_ZONE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        pad_present <= 1'b0;
        stick_x <= '0;
        stick_y <= '0;
        trigger_level <= '0;
        pad_jump <= 1'b0;
        key_move_x <= '0;
        key_move_y <= '0;
        key_run <= 1'b0;
        key_jump <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_sample(directed[i].s, directed[i].known, directed[i].m);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(sdm_pkg::REG_DEAD_ZONE, 15'd0);
                    write_reg(sdm_pkg::REG_RUN_THR, 15'd0);
                end
                1: begin
                    write_reg(sdm_pkg::REG_DEAD_ZONE, 15'd16367);
                    write_reg(sdm_pkg::REG_RUN_THR, 15'd16384);
                end
                2: begin
                    write_reg(sdm_pkg::REG_DEAD_ZONE, 15'h3fff);
                    write_reg(sdm_pkg::REG_RUN_THR, 15'h7fff);
                end
                3: begin
                    write_reg(sdm_pkg::REG_DEAD_ZONE, 15'd1);
                    write_reg(sdm_pkg::REG_RUN_THR, 15'd1);
                end
                default: begin
                    write_reg(sdm_pkg::REG_DEAD_ZONE, 15'($urandom_range(0, 16383)));
                    write_reg(sdm_pkg::REG_RUN_THR, 15'($urandom_range(0, 32767)));
                end
            endcase
            cfg_we <= 1'b0;
            for (int k = 0; k < N_RANDOM / 8; k++) send_sample(rand_sample(), 1'b0, none);
            drain();
        end

        feeding_done = 1'b1;
        drain();
        if (n_errors == 0 && expected_moves.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
